FILE: design/getd_pkg.sv
package getd_pkg;

    localparam int NV     = 32;
    localparam int MAXDEG = 8;
    localparam int VW     = 5;
    localparam int DW     = (MAXDEG > 1) ? $clog2(MAXDEG) : 1;
    localparam int CW     = $clog2(MAXDEG + 1);
    localparam int AW     = VW + DW;
    localparam int WTW    = 16;
    localparam int RW     = VW + WTW;
    localparam int RDEPTH = NV * (1 << DW);
    localparam int VCW    = 6;
    localparam logic [VCW-1:0] VCOUNT_RESET = VCW'(20);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_WALK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_MISS    = 2'd1,
        ST_DONE    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_SCAN, S_CMP, S_DECIDE, S_SHRD, S_SHWR, S_SHEND,
        S_WSTART, S_WTOP, S_WCHK, S_WLAST
    } state_t;

    typedef enum logic [3:0] {
        A_NOP, A_LOAD, A_SCAN_RD, A_CMP, A_INSERT, A_SH_INIT, A_SH_RD,
        A_SH_WR, A_SH_END, A_W_START, A_W_POP, A_W_NEXT, A_W_PUSH
    } act_t;

    typedef struct packed {
        act_t    act;
        logic    emit;
        status_t st;
        logic    use_wt;
        logic    use_pend;
        logic    last;
    } getd_cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic in_ok;
        op_t  op;
        logic idx_zero;
        logic match;
        logic found;
        logic cnt_full;
        logic sh_more;
        logic top_zero;
        logic sp_zero;
        logic nb_seen;
        logic slot_free;
    } getd_sts_t;

endpackage

FILE: design/graph_edge_table_dfs.sv
// Directed weighted graph store with per-vertex neighbor lists (newest first)
// and a depth-first walk.
//
// Channels: in (op, from_vertex, to_vertex, weight) and out (status,
// edge_weight, visited_vertex, last) use valid/ready; a transfer happens on a
// clock edge with both high. cfg carries vertex_count; it is always ready and
// is meant to be written only while the block is idle.
//
// One input is handled at a time. An edge op scans its source list in the
// neighbor RAM one entry at a time, a read state then a compare state
// (registered read); a remove then shifts the later entries down, each read
// and then written back one place lower. A walk follows edges and pops the
// stack, and gives one result per vertex reached, last on the final one
// (each visit is held back one step so last can be flagged).
//
// Results leave through a one-entry output register; if the receiver stalls
// the sequencer waits on its next result, so at most one further input is
// taken while a result is held.
// Reset clears counts, the output valid flag and the controller; vertex_count
// returns to 20. The neighbor RAM is not cleared: entries past a list's count
// are never read.
module graph_edge_table_dfs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [getd_pkg::VCW-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [getd_pkg::VW-1:0]       from_vertex,
    input  logic [getd_pkg::VW-1:0]       to_vertex,
    input  logic [getd_pkg::WTW-1:0]      weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [getd_pkg::WTW-1:0]      edge_weight,
    output logic [getd_pkg::VW-1:0]       visited_vertex,
    output logic                          last
);
    import getd_pkg::*;

    getd_cmd_t cmd;
    getd_sts_t sts;

    // config register has no side effects; accept any time
    assign cfg_ready = 1'b1;

    getd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    getd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .op             (op),
        .from_vertex    (from_vertex),
        .to_vertex      (to_vertex),
        .weight         (weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .edge_weight    (edge_weight),
        .visited_vertex (visited_vertex),
        .last           (last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

FILE: design/getd_ram.sv
module getd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/getd_ctrl.sv
module getd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  getd_pkg::getd_sts_t sts,
    output getd_pkg::getd_cmd_t cmd
);
    import getd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!sts.in_ok)
                        state_next = S_ERR;
                    else if (sts.in_op == OP_WALK)
                        state_next = S_WSTART;
                    else
                        state_next = S_SCAN;
                end
            end
            S_ERR:    if (sts.slot_free) state_next = S_IDLE;
            S_SCAN:   state_next = sts.idx_zero ? S_DECIDE : S_CMP;
            S_CMP:    state_next = sts.match ? S_DECIDE : S_SCAN;
            S_DECIDE:
            begin
                if (sts.op == OP_REMOVE && sts.found)
                    state_next = S_SHRD;
                else if (sts.slot_free)
                    state_next = S_IDLE;
            end
            S_SHRD:   state_next = sts.sh_more ? S_SHWR : S_SHEND;
            S_SHWR:   state_next = S_SHRD;
            S_SHEND:  if (sts.slot_free) state_next = S_IDLE;
            S_WSTART: state_next = S_WTOP;
            S_WTOP:
            begin
                if (!sts.top_zero)
                    state_next = S_WCHK;
                else if (sts.sp_zero)
                    state_next = S_WLAST;
            end
            S_WCHK:
            begin
                if (sts.nb_seen || sts.slot_free)
                    state_next = S_WTOP;
            end
            S_WLAST:  if (sts.slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.act      = A_NOP;
        cmd.emit     = 1'b0;
        cmd.st       = ST_DONE;
        cmd.use_wt   = 1'b0;
        cmd.use_pend = 1'b0;
        cmd.last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.act = A_LOAD;
            end
            S_ERR:
            begin
                cmd.emit = sts.slot_free;
                cmd.st   = ST_INVALID;
            end
            S_SCAN:   if (!sts.idx_zero) cmd.act = A_SCAN_RD;
            S_CMP:    cmd.act = A_CMP;
            S_DECIDE:
            begin
                case (sts.op)
                    OP_INSERT:
                    begin
                        cmd.emit = sts.slot_free;
                        if (sts.found)
                            cmd.st = ST_MISS;
                        else if (sts.cnt_full)
                            cmd.st = ST_FULL;
                        else if (sts.slot_free)
                            cmd.act = A_INSERT;
                    end
                    OP_REMOVE:
                    begin
                        if (sts.found)
                        begin
                            cmd.act = A_SH_INIT;
                        end
                        else
                        begin
                            cmd.emit = sts.slot_free;
                            cmd.st   = ST_MISS;
                        end
                    end
                    default:
                    begin
                        cmd.emit   = sts.slot_free;
                        cmd.st     = sts.found ? ST_DONE : ST_MISS;
                        cmd.use_wt = sts.found;
                    end
                endcase
            end
            S_SHRD:   if (sts.sh_more) cmd.act = A_SH_RD;
            S_SHWR:   cmd.act = A_SH_WR;
            S_SHEND:
            begin
                if (sts.slot_free)
                begin
                    cmd.act  = A_SH_END;
                    cmd.emit = 1'b1;
                end
            end
            S_WSTART: cmd.act = A_W_START;
            S_WTOP:
            begin
                if (!sts.top_zero)
                    cmd.act = A_W_NEXT;
                else if (!sts.sp_zero)
                    cmd.act = A_W_POP;
            end
            S_WCHK:
            begin
                if (!sts.nb_seen && sts.slot_free)
                begin
                    cmd.act      = A_W_PUSH;
                    cmd.emit     = 1'b1;
                    cmd.use_pend = 1'b1;
                    cmd.last     = 1'b0;
                end
            end
            S_WLAST:
            begin
                cmd.emit     = sts.slot_free;
                cmd.use_pend = 1'b1;
            end
            default:  cmd.act = A_NOP;
        endcase
    end

endmodule

FILE: design/getd_dp.sv
module getd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [getd_pkg::VCW-1:0]      cfg_data,
    input  logic [1:0]                    op,
    input  logic [getd_pkg::VW-1:0]       from_vertex,
    input  logic [getd_pkg::VW-1:0]       to_vertex,
    input  logic [getd_pkg::WTW-1:0]      weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [getd_pkg::WTW-1:0]      edge_weight,
    output logic [getd_pkg::VW-1:0]       visited_vertex,
    output logic                          last,
    input  getd_pkg::getd_cmd_t           cmd,
    output getd_pkg::getd_sts_t           sts
);
    import getd_pkg::*;

    logic [VCW-1:0] vcount_reg;
    op_t            op_reg;
    logic [VW-1:0]  a_reg, b_reg;
    logic [WTW-1:0] w_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  idx_reg;
    logic           found_reg;
    logic [CW-1:0]  pos_reg;
    logic [WTW-1:0] wt_reg;
    logic [VW-1:0]  pend_reg;
    logic [VW-1:0]  sp_reg;
    logic [CW-1:0]  count_reg [NV];
    logic [VW-1:0]  stk_vtx_reg [NV];
    logic [CW-1:0]  stk_pos_reg [NV];
    logic [NV-1:0]  visited_reg;

    logic           out_valid_reg;
    status_t        out_st_reg;
    logic [WTW-1:0] out_wt_reg;
    logic [VW-1:0]  out_vis_reg;
    logic           out_last_reg;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [RW-1:0]  ram_wdata, ram_rdata;
    logic [VW-1:0]  nb;
    logic [WTW-1:0] rd_wt;
    logic [VW-1:0]  cnt_raddr;
    logic [CW-1:0]  cnt_rd;
    logic [VW-1:0]  top_vtx;
    logic [CW-1:0]  top_pos;
    logic           slot_free;

    function automatic logic vtx_ok(logic [VW-1:0] v, logic [VCW-1:0] vc);
        return ({1'b0, v} < vc) && (32'(v) < NV);
    endfunction

    getd_ram #(.WIDTH(RW), .DEPTH(RDEPTH)) u_store (
        .clk   (clk),
        .wr_en (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nb      = ram_rdata[RW-1:WTW];
    assign rd_wt   = ram_rdata[WTW-1:0];
    assign top_vtx = stk_vtx_reg[sp_reg];
    assign top_pos = stk_pos_reg[sp_reg];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.act)
            A_LOAD:    cnt_raddr = from_vertex;
            A_W_START: cnt_raddr = a_reg;
            default:   cnt_raddr = nb;
        endcase
    end
    assign cnt_rd = count_reg[cnt_raddr];

    // store port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {a_reg, idx_reg[DW-1:0]};
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = {a_reg, idx_reg[DW-1:0] - DW'(1)};
        case (cmd.act)
            A_SCAN_RD: ram_re = 1'b1;
            A_SH_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = {a_reg, idx_reg[DW-1:0] + DW'(1)};
            end
            A_W_NEXT:
            begin
                ram_re    = 1'b1;
                ram_raddr = {top_vtx, top_pos[DW-1:0] - DW'(1)};
            end
            A_INSERT:
            begin
                ram_we    = 1'b1;
                ram_waddr = {a_reg, cnt_reg[DW-1:0]};
                ram_wdata = {b_reg, w_reg};
            end
            A_SH_WR:   ram_we = 1'b1;
            default:   ram_re = 1'b0;
        endcase
    end

    always_comb
    begin
        sts.in_op     = op_t'(op);
        sts.in_ok     = vtx_ok(from_vertex, vcount_reg) &&
                        (op_t'(op) == OP_WALK || vtx_ok(to_vertex, vcount_reg));
        sts.op        = op_reg;
        sts.idx_zero  = (idx_reg == '0);
        sts.match     = (nb == b_reg);
        sts.found     = found_reg;
        sts.cnt_full  = (32'(cnt_reg) >= MAXDEG);
        sts.sh_more   = ({1'b0, idx_reg} + (CW+1)'(1)) < {1'b0, cnt_reg};
        sts.top_zero  = (top_pos == '0);
        sts.sp_zero   = (sp_reg == '0);
        sts.nb_seen   = visited_reg[nb];
        sts.slot_free = slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                vcount_reg <= cfg_data;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.act == A_INSERT)
                count_reg[a_reg] <= cnt_reg + CW'(1);
            if (cmd.act == A_SH_END)
                count_reg[a_reg] <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_st_reg   <= cmd.st;
            out_wt_reg   <= cmd.use_wt ? wt_reg : '0;
            out_vis_reg  <= cmd.use_pend ? pend_reg : '0;
            out_last_reg <= cmd.last;
        end
        case (cmd.act)
            A_LOAD:
            begin
                op_reg    <= op_t'(op);
                a_reg     <= from_vertex;
                b_reg     <= to_vertex;
                w_reg     <= weight;
                cnt_reg   <= cnt_rd;
                idx_reg   <= cnt_rd;
                found_reg <= 1'b0;
            end
            A_SCAN_RD: idx_reg <= idx_reg - CW'(1);
            A_CMP:
            begin
                if (nb == b_reg)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= idx_reg;
                    wt_reg    <= rd_wt;
                end
            end
            A_SH_INIT: idx_reg <= pos_reg;
            A_SH_WR:   idx_reg <= idx_reg + CW'(1);
            A_W_START:
            begin
                // marks cleared, start vertex marked
                visited_reg        <= NV'(1) << a_reg;
                sp_reg             <= '0;
                stk_vtx_reg[0]     <= a_reg;
                stk_pos_reg[0]     <= cnt_rd;
                pend_reg           <= a_reg;
            end
            A_W_POP:   sp_reg <= sp_reg - VW'(1);
            A_W_NEXT:  stk_pos_reg[sp_reg] <= top_pos - CW'(1);
            A_W_PUSH:
            begin
                visited_reg[nb]               <= 1'b1;
                pend_reg                      <= nb;
                sp_reg                        <= sp_reg + VW'(1);
                stk_vtx_reg[sp_reg + VW'(1)]  <= nb;
                stk_pos_reg[sp_reg + VW'(1)]  <= cnt_rd;
            end
            default:   pend_reg <= pend_reg;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign edge_weight    = out_wt_reg;
    assign visited_vertex = out_vis_reg;
    assign last           = out_last_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import getd_pkg::*;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // DUT ports
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [VCW-1:0]   cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       op = '0;
    logic [VW-1:0]    from_vertex = '0;
    logic [VW-1:0]    to_vertex = '0;
    logic [WTW-1:0]   weight = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic [WTW-1:0]   edge_weight;
    logic [VW-1:0]    visited_vertex;
    logic             last;

    graph_edge_table_dfs dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .from_vertex    (from_vertex),
        .to_vertex      (to_vertex),
        .weight         (weight),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .edge_weight    (edge_weight),
        .visited_vertex (visited_vertex),
        .last           (last)
    );

    // One expected result: the four output fields in order.
    typedef struct packed {
        status_t        st;
        logic [WTW-1:0] wt;
        logic [VW-1:0]  vis;
        logic           lst;
    } graph_result_t;

    // Shadow of the graph held by the block.
    logic [VW-1:0]  adj_dest [NV][MAXDEG];
    logic [WTW-1:0] adj_wt   [NV][MAXDEG];
    int             adj_len  [NV];
    int             vcount;

    graph_result_t  pending_results[$];

    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  walks_sent = 0;
    int  cycle_count = 0;

    // Idle/stall percentages, changed by phase.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;   // long receiver hold-off
    int  hold_cycles = 0;

    localparam int CYCLE_LIMIT = 2_000_000;

    function automatic bit vertex_ok(int v);
        int lim;
        lim = (vcount > NV) ? NV : vcount;
        return v < lim;
    endfunction

    // Newest matching position in list v, or -1.
    function automatic int edge_pos(int v, int d);
        for (int i = adj_len[v] - 1; i >= 0; i--)
            if (adj_dest[v][i] == d)
                return i;
        return -1;
    endfunction

    function automatic graph_result_t mk(status_t s, int w, int vis, bit l);
        graph_result_t r;
        r.st = s;
        r.wt = WTW'(w);
        r.vis = VW'(vis);
        r.lst = l;
        return r;
    endfunction

    // Compute the results of one op and update the shadow graph.
    task automatic predict_graph_op(op_t o, int a, int b, int w);
        int pos;
        int n;
        int sp;
        int nb;
        bit seen [NV];
        int stk_v [NV];
        int stk_p [NV];
        graph_result_t walk_out[$];
        if (o == OP_WALK)
        begin
            if (!vertex_ok(a))
            begin
                pending_results.push_back(mk(ST_INVALID, 0, 0, 1'b1));
                return;
            end
            foreach (seen[i]) seen[i] = 1'b0;
            seen[a] = 1'b1;
            walk_out.push_back(mk(ST_DONE, 0, a, 1'b0));
            n = 1;
            sp = 0;
            stk_v[0] = a;
            stk_p[0] = adj_len[a];
            while (sp >= 0)
            begin
                if (stk_p[sp] == 0)
                begin
                    sp--;
                end
                else
                begin
                    stk_p[sp]--;
                    nb = adj_dest[stk_v[sp]][stk_p[sp]];
                    if (!seen[nb] && sp + 1 < NV && n < 32)
                    begin
                        seen[nb] = 1'b1;
                        walk_out.push_back(mk(ST_DONE, 0, nb, 1'b0));
                        n++;
                        sp++;
                        stk_v[sp] = nb;
                        stk_p[sp] = adj_len[nb];
                    end
                end
            end
            walk_out[walk_out.size() - 1].lst = 1'b1;
            foreach (walk_out[i]) pending_results.push_back(walk_out[i]);
            return;
        end
        if (!vertex_ok(a) || !vertex_ok(b))
        begin
            pending_results.push_back(mk(ST_INVALID, 0, 0, 1'b1));
            return;
        end
        pos = edge_pos(a, b);
        case (o)
            OP_INSERT:
            begin
                if (pos >= 0)
                    pending_results.push_back(mk(ST_MISS, 0, 0, 1'b1));
                else if (adj_len[a] >= MAXDEG)
                    pending_results.push_back(mk(ST_FULL, 0, 0, 1'b1));
                else
                begin
                    adj_dest[a][adj_len[a]] = VW'(b);
                    adj_wt[a][adj_len[a]] = WTW'(w);
                    adj_len[a]++;
                    pending_results.push_back(mk(ST_DONE, 0, 0, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                if (pos < 0)
                    pending_results.push_back(mk(ST_MISS, 0, 0, 1'b1));
                else
                begin
                    for (int i = pos; i + 1 < adj_len[a]; i++)
                    begin
                        adj_dest[a][i] = adj_dest[a][i + 1];
                        adj_wt[a][i] = adj_wt[a][i + 1];
                    end
                    adj_len[a]--;
                    pending_results.push_back(mk(ST_DONE, 0, 0, 1'b1));
                end
            end
            default:
            begin
                if (pos < 0)
                    pending_results.push_back(mk(ST_MISS, 0, 0, 1'b1));
                else
                    pending_results.push_back(mk(ST_DONE, adj_wt[a][pos], 0, 1'b1));
            end
        endcase
    endtask

    // Offer one op; keep valid up until the transfer. Prediction is made at
    // the accepting edge so ordering against results is preserved. Valid is
    // dropped only while the sender idles or drains.
    task automatic send_graph_op(op_t o, int a, int b, int w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        from_vertex <= VW'(a);
        to_vertex   <= VW'(b);
        weight      <= WTW'(w);
        do
            @(posedge clk);
        while (!in_ready);
        predict_graph_op(o, a, b, w);
        items_sent++;
        if (o == OP_WALK) walks_sent++;
    endtask

    // Stop offering, wait for the block to drain, then let it settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_vertex_count(int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= VCW'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vcount = value;
    endtask

    // Receiver: random stalls plus the long hold-off.
    always @(posedge clk)
    begin
        if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        graph_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected transfer: status=%0d vis=%0d", status, visited_vertex);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    error_count++;
                end
                if (edge_weight !== exp_r.wt)
                begin
                    $error("edge_weight: expected %0d, got %0d", exp_r.wt, edge_weight);
                    error_count++;
                end
                if (visited_vertex !== exp_r.vis)
                begin
                    $error("visited_vertex: expected %0d, got %0d", exp_r.vis,
                           visited_vertex);
                    error_count++;
                end
                if (last !== exp_r.lst)
                begin
                    $error("last: expected %0d, got %0d", exp_r.lst, last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("graph_edge_table_dfs verification failed");
            $finish;
        end
    end

    // Random op biased toward a small vertex range so lists fill and walks
    // go deep; a few ops hit out-of-range vertices.
    task automatic random_graph_op(int span);
        int  a;
        int  b;
        int  r;
        op_t o;
        r = $urandom_range(99);
        if (r < 45)      o = OP_INSERT;
        else if (r < 65) o = OP_REMOVE;
        else if (r < 85) o = OP_QUERY;
        else             o = OP_WALK;
        if ($urandom_range(19) == 0)
        begin
            a = $urandom_range(31);
            b = $urandom_range(31);
        end
        else
        begin
            a = $urandom_range(span - 1);
            b = $urandom_range(span - 1);
        end
        send_graph_op(o, a, b, $urandom_range(16'hFFFF));
    endtask

    task automatic test_directed_edges();
        send_graph_op(OP_INSERT, 0, 1, 16'h0000);
        send_graph_op(OP_INSERT, 0, 1, 16'h1234);      // duplicate
        send_graph_op(OP_INSERT, 19, 0, 16'hFFFF);
        send_graph_op(OP_QUERY, 19, 0, 0);
        send_graph_op(OP_QUERY, 0, 19, 0);              // not found
        send_graph_op(OP_INSERT, 20, 0, 5);             // invalid source
        send_graph_op(OP_INSERT, 0, 31, 5);             // invalid dest
        for (int d = 2; d < 10; d++)                     // fill list, then full
            send_graph_op(OP_INSERT, 0, d, 16'hA5A5 ^ d);
        send_graph_op(OP_INSERT, 0, 1, 7);              // full list, duplicate
        send_graph_op(OP_REMOVE, 0, 5, 0);              // middle removal
        send_graph_op(OP_REMOVE, 0, 5, 0);              // now missing
        send_graph_op(OP_QUERY, 0, 6, 0);
        send_graph_op(OP_WALK, 0, 0, 0);
        send_graph_op(OP_WALK, 31, 0, 0);               // invalid start
        send_graph_op(OP_WALK, 12, 0, 0);               // lone vertex
    endtask

    task automatic test_random_phase(int count, int span, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) random_graph_op(span);
    endtask

    // Receiver holds off while the sender keeps offering ops.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        recv_hold = 1'b1;
        fork
            begin
                while (hold_cycles < 400)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                recv_hold = 1'b0;
            end
            repeat (20) random_graph_op(8);
        join
        drain_results();
    endtask

    // Shrink vertex_count below stored edges; walks still follow them.
    task automatic test_vertex_count();
        write_vertex_count(1);
        send_graph_op(OP_WALK, 0, 0, 0);
        send_graph_op(OP_INSERT, 0, 1, 3);
        write_vertex_count(0);
        send_graph_op(OP_WALK, 0, 0, 0);
        send_graph_op(OP_QUERY, 0, 0, 0);
        write_vertex_count(63);
        test_random_phase(60, 32, 25, 25);
        send_graph_op(OP_WALK, 31, 0, 0);
        write_vertex_count(32);
        test_random_phase(40, 32, 0, 0);
        write_vertex_count(5);
        test_random_phase(30, 8, 48, 0);
        write_vertex_count(20);
    endtask

    initial
    begin
        vcount = 20;
        foreach (adj_len[i]) adj_len[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_phase(45, 8, 0, 0);
        test_random_phase(70, 8, 48, 0);
        test_random_phase(70, 10, 0, 48);
        test_random_phase(60, 6, 25, 25);
        test_backpressure();
        test_vertex_count();
        test_random_phase(50, 20, 25, 25);

        drain_results();
        $display("covered %0d ops (%0d walks), %0d results checked", items_sent,
                 walks_sent, results_seen);
        $display("edge ops, full lists, invalid vertices, walks, vertex_count sweep");
        if (error_count == 0 && pending_results.size() == 0)
            $display("graph_edge_table_dfs verification clean");
        else
            $display("graph_edge_table_dfs verification failed");
        $finish;
    end

endmodule

FILE: graph_edge_table_dfs.f
design/getd_pkg.sv
design/getd_ram.sv
design/getd_ctrl.sv
design/getd_dp.sv
design/graph_edge_table_dfs.sv
tb/tb_top.sv
